@@ rtl/core/sorted_key_table_insert_delete_core_defines.svh @@
// Assertion macros for the sorted key table core checker.
// Users need clk_i and rst_ni in scope; no other dependencies.
`ifndef SORTED_KEY_TABLE_INSERT_DELETE_CORE_DEFINES_SVH
`define SORTED_KEY_TABLE_INSERT_DELETE_CORE_DEFINES_SVH

// Same-cycle implication, reset masked.
`define SKTID_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sktid: same-cycle check failed");

// Next-cycle implication, reset masked.
`define SKTID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sktid: next-cycle check failed");

`endif

@@ rtl/core/sktid_pkg.sv @@
// Shared types and constants of the sorted key table core.
// No dependencies.
`default_nettype none

package sktid_pkg;

  localparam int unsigned KeyW         = 32;
  localparam int unsigned PayloadW     = 32;
  localparam int unsigned StatusW      = 3;
  localparam int unsigned RecordCountW = 5;

  localparam logic KindInsert = 1'b0;
  localparam logic KindDelete = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StInserted = 3'd0,
    StDeleted  = 3'd1,
    StNotFound = 3'd2,
    StEmpty    = 3'd3,
    StFull     = 3'd4
  } status_e;

  // Result of the shared key comparator.
  typedef struct packed {
    logic lt;  // stored key < item key, signed
    logic eq;
  } cmp_res_t;

endpackage

`default_nettype wire

@@ rtl/core/sktid_mem.sv @@
// Record store: key and payload arrays, one write port, one registered read port.
// Depends on sktid_pkg.
`default_nettype none

module sktid_mem import sktid_pkg::*; #(
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw   = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [Aw-1:0]       waddr_i,
  input  logic [KeyW-1:0]     wkey_i,
  input  logic [PayloadW-1:0] wpay_i,
  input  logic [Aw-1:0]       raddr_i,
  output logic [KeyW-1:0]     rkey_o,
  output logic [PayloadW-1:0] rpay_o
);

  logic [KeyW-1:0]     key_mem [Depth];
  logic [PayloadW-1:0] pay_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i] <= wkey_i;
      pay_mem[waddr_i] <= wpay_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rkey_o <= key_mem[raddr_i];
    rpay_o <= pay_mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/core/sktid_cmp.sv @@
// Shared key comparator: signed less-than and equality on one key pair.
// Depends on sktid_pkg.
`default_nettype none

module sktid_cmp import sktid_pkg::*; (
  input  logic [KeyW-1:0] stored_i,
  input  logic [KeyW-1:0] probe_i,
  output cmp_res_t        res_o
);

  assign res_o.lt = $signed(stored_i) < $signed(probe_i);
  assign res_o.eq = stored_i == probe_i;

endmodule

`default_nettype wire

@@ rtl/core/sorted_key_table_insert_delete_core.sv @@
// Sorted key table core: sequencer around one record memory and one comparator.
// Depends on sktid_pkg, sktid_mem, sktid_cmp.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------
//   command  | start in, busy out     | kind_i, key_i, payload_i
//   result   | done_o strobe, 1 cycle | status_o, record_count_o
//
// Insert walks down from the top, an SRead and an SCmp state per record it moves up,
//   then writes the new record in SCmp, or in SPut at slot 0.
// Delete scans the whole table, an SRead and an SCmp state per record.
// Full insert and empty delete answer the cycle after accept.
// The single memory read port (registered data) sets the SRead/SCmp step pair.
// Reset clears the count; stores need no clearing. The receiver cannot stall.
`default_nettype none

module sorted_key_table_insert_delete_core import sktid_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    kind_i,
  input  logic signed [KeyW-1:0]  key_i,
  input  logic [PayloadW-1:0]     payload_i,
  output logic                    done_o,
  output logic [StatusW-1:0]      status_o,
  output logic [RecordCountW-1:0] record_count_o
);

  localparam int unsigned Aw = $clog2(CAPACITY);
  localparam int unsigned Cw = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    SIdle,
    SRead,
    SCmp,
    SPut
  } state_e;

  state_e              state_q, state_d;
  logic [Cw-1:0]       idx_q, idx_d;
  logic [Cw-1:0]       count_q, count_d;
  logic                found_q, found_d;
  logic                kind_q, kind_d;
  logic [KeyW-1:0]     key_q, key_d;
  logic [PayloadW-1:0] pay_q, pay_d;
  logic                done_q, done_d;
  status_e             status_q, status_d;

  logic                we;
  logic [Cw-1:0]       waddr;
  logic [KeyW-1:0]     wkey;
  logic [PayloadW-1:0] wpay;
  logic [Cw-1:0]       raddr;
  logic [KeyW-1:0]     rkey;
  logic [PayloadW-1:0] rpay;
  cmp_res_t            cmp;

  // Insert reads the record below the current slot, delete reads the slot itself.
  assign raddr = (kind_q == KindInsert) ? idx_q - Cw'(1) : idx_q;

  sktid_mem #(.Depth(CAPACITY)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr[Aw-1:0]),
    .wkey_i  (wkey),
    .wpay_i  (wpay),
    .raddr_i (raddr[Aw-1:0]),
    .rkey_o  (rkey),
    .rpay_o  (rpay)
  );

  sktid_cmp u_cmp (
    .stored_i (rkey),
    .probe_i  (key_q),
    .res_o    (cmp)
  );

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    count_d  = count_q;
    found_d  = found_q;
    kind_d   = kind_q;
    key_d    = key_q;
    pay_d    = pay_q;
    done_d   = 1'b0;
    status_d = status_q;
    we       = 1'b0;
    waddr    = idx_q;
    wkey     = key_q;
    wpay     = pay_q;

    unique case (state_q)
      SIdle: begin
        if (start) begin
          kind_d  = kind_i;
          key_d   = key_i;
          pay_d   = payload_i;
          found_d = 1'b0;
          if (kind_i == KindInsert) begin
            if (count_q == Cw'(CAPACITY)) begin
              done_d   = 1'b1;
              status_d = StFull;
            end else begin
              idx_d   = count_q;
              state_d = (count_q == '0) ? SPut : SRead;
            end
          end else begin
            if (count_q == '0) begin
              done_d   = 1'b1;
              status_d = StEmpty;
            end else begin
              idx_d   = '0;
              state_d = SRead;
            end
          end
        end
      end

      SRead: begin
        state_d = SCmp;
      end

      SCmp: begin
        if (kind_q == KindInsert) begin
          we = 1'b1;
          if (cmp.lt) begin
            // slot idx is the insert point
            count_d  = count_q + Cw'(1);
            done_d   = 1'b1;
            status_d = StInserted;
            state_d  = SIdle;
          end else begin
            wkey  = rkey;
            wpay  = rpay;
            idx_d = idx_q - Cw'(1);
            state_d = (idx_q == Cw'(1)) ? SPut : SRead;
          end
        end else begin
          // past the match, close the gap one slot down
          if (found_q) begin
            we    = 1'b1;
            waddr = idx_q - Cw'(1);
            wkey  = rkey;
            wpay  = rpay;
          end
          found_d = found_q | cmp.eq;
          if (idx_q + Cw'(1) == count_q) begin
            done_d  = 1'b1;
            state_d = SIdle;
            if (found_q || cmp.eq) begin
              count_d  = count_q - Cw'(1);
              status_d = StDeleted;
            end else begin
              status_d = StNotFound;
            end
          end else begin
            idx_d   = idx_q + Cw'(1);
            state_d = SRead;
          end
        end
      end

      SPut: begin
        we       = 1'b1;
        count_d  = count_q + Cw'(1);
        done_d   = 1'b1;
        status_d = StInserted;
        state_d  = SIdle;
      end

      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      idx_q    <= '0;
      count_q  <= '0;
      found_q  <= 1'b0;
      kind_q   <= KindInsert;
      key_q    <= '0;
      pay_q    <= '0;
      done_q   <= 1'b0;
      status_q <= StInserted;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      count_q  <= count_d;
      found_q  <= found_d;
      kind_q   <= kind_d;
      key_q    <= key_d;
      pay_q    <= pay_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  assign busy           = state_q != SIdle;
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign record_count_o = RecordCountW'(count_q);

endmodule

`default_nettype wire

@@ rtl/core/sktid_checker.sv @@
// Port-level checker for the sorted key table core, bound to the top level.
// Depends on sktid_pkg and sorted_key_table_insert_delete_core_defines.svh.
`default_nettype none
`include "sorted_key_table_insert_delete_core_defines.svh"

module sktid_checker import sktid_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    done_o,
  input logic [StatusW-1:0]      status_o,
  input logic [RecordCountW-1:0] record_count_o
);

  // a result beat lands only when the core is free again
  `SKTID_ASSERT_NOW(a_done_not_busy, done_o, !busy)
  // an accepted command either starts work or answers at once
  `SKTID_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done_o)
  // an empty table reports zero records
  `SKTID_ASSERT_NOW(a_empty_count, done_o && status_o == StEmpty, record_count_o == '0)
  // a full table reports the capacity
  `SKTID_ASSERT_NOW(a_full_count, done_o && status_o == StFull,
                    record_count_o == RecordCountW'(CAPACITY))
  // table changes always go through the sequencer
  `SKTID_ASSERT_NOW(a_change_was_busy,
                    done_o && (status_o == StInserted || status_o == StDeleted),
                    $past(busy))

endmodule

bind sorted_key_table_insert_delete_core sktid_checker #(.CAPACITY(CAPACITY)) u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .status_o       (status_o),
  .record_count_o (record_count_o)
);

`default_nettype wire

@@ tb/sorted_key_table_insert_delete_core_test.sv @@
// Testbench for the sorted key table core: directed and random insert/delete beats,
// checked against an in-bench model of the sorted table. Depends on sktid_pkg and the core.
`timescale 1ns / 100ps
`default_nettype none

module sorted_key_table_insert_delete_core_test;
  import sktid_pkg::*;

  localparam int unsigned CAPACITY = 16;

  typedef struct {
    logic                   kind;
    logic signed [KeyW-1:0] key;
    logic [PayloadW-1:0]    payload;
  } table_cmd_t;

  typedef struct {
    status_e                 status;
    logic [RecordCountW-1:0] count;
  } table_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic                    kind_i;
  logic signed [KeyW-1:0]  key_i;
  logic [PayloadW-1:0]     payload_i;
  logic                    done_o;
  logic [StatusW-1:0]      status_o;
  logic [RecordCountW-1:0] record_count_o;

  sorted_key_table_insert_delete_core #(.CAPACITY(CAPACITY)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .key_i         (key_i),
    .payload_i     (payload_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .record_count_o(record_count_o)
  );

  table_cmd_t    pending_cmds[$];
  table_result_t expected_results[$];
  int            total_cmds;
  int            accepted_cmds;
  int            errors;
  bit            beat_taken;

  // Table model: kept sorted, equal keys newest first.
  logic signed [KeyW-1:0] tbl_key[CAPACITY];
  logic [PayloadW-1:0]    tbl_payload[CAPACITY];
  int                     tbl_count;

  // Presence list used only to steer generated keys toward stored ones, for deletes and repeat inserts.
  logic signed [KeyW-1:0] live_keys[$];

  function automatic table_result_t table_apply(input table_cmd_t c);
    table_result_t r;
    int pos;
    int i;
    if (c.kind == KindInsert) begin
      if (tbl_count >= CAPACITY) begin
        r.status = StFull;
      end else begin
        pos = 0;
        while (pos < tbl_count && tbl_key[pos] < c.key) pos++;
        for (i = tbl_count; i > pos; i--) begin
          tbl_key[i]     = tbl_key[i-1];
          tbl_payload[i] = tbl_payload[i-1];
        end
        tbl_key[pos]     = c.key;
        tbl_payload[pos] = c.payload;
        tbl_count++;
        r.status = StInserted;
      end
    end else if (tbl_count == 0) begin
      r.status = StEmpty;
    end else begin
      pos = 0;
      while (pos < tbl_count && tbl_key[pos] != c.key) pos++;
      if (pos >= tbl_count) begin
        r.status = StNotFound;
      end else begin
        for (i = pos; i + 1 < tbl_count; i++) begin
          tbl_key[i]     = tbl_key[i+1];
          tbl_payload[i] = tbl_payload[i+1];
        end
        tbl_count--;
        r.status = StDeleted;
      end
    end
    r.count = tbl_count[RecordCountW-1:0];
    return r;
  endfunction

  task automatic queue_cmd(input logic kind, input logic signed [KeyW-1:0] key,
                           input logic [PayloadW-1:0] payload);
    table_cmd_t c;
    int i;
    c.kind    = kind;
    c.key     = key;
    c.payload = payload;
    pending_cmds.push_back(c);
    if (kind == KindInsert) begin
      if (live_keys.size() < CAPACITY) live_keys.push_back(key);
    end else begin
      for (i = 0; i < live_keys.size(); i++) begin
        if (live_keys[i] == key) begin
          live_keys.delete(i);
          break;
        end
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Driver: start stays high until the beat is taken; random holds between beats.
  bit cmd_live;
  int hold_cycles;
  int cmds_issued;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (cmd_live && beat_taken) cmd_live = 1'b0;
      if (!cmd_live) begin
        if (hold_cycles > 0) begin
          hold_cycles--;
        end else if (pending_cmds.size() > 0) begin
          // no random holds in the middle of the run
          if ((cmds_issued < 700 || cmds_issued > 1000) && $urandom_range(0, 99) < 8) begin
            hold_cycles = $urandom_range(0, 4);
          end else begin
            kind_i    <= pending_cmds[0].kind;
            key_i     <= pending_cmds[0].key;
            payload_i <= pending_cmds[0].payload;
            void'(pending_cmds.pop_front());
            cmd_live = 1'b1;
            cmds_issued++;
          end
        end
      end
      start <= cmd_live;
    end
  end

  // Monitor: check results first, then predict for a beat taken at this edge.
  always @(posedge clk_i) begin
    table_cmd_t    c;
    table_result_t r;
    beat_taken = 1'b0;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status %0d count %0d", $time, status_o,
                   record_count_o);
          errors++;
        end else begin
          r = expected_results.pop_front();
          if (status_o !== r.status) begin
            $display("%0t: status expected %0d got %0d", $time, r.status, status_o);
            errors++;
          end
          if (record_count_o !== r.count) begin
            $display("%0t: record_count expected %0d got %0d", $time, r.count,
                     record_count_o);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        c.kind    = kind_i;
        c.key     = key_i;
        c.payload = payload_i;
        expected_results.push_back(table_apply(c));
        accepted_cmds++;
        beat_taken = 1'b1;
      end
    end
  end

  initial begin
    int   i;
    int   n;
    int   mode_left;
    bit   fill_mode;
    logic signed [KeyW-1:0] k;

    rst_ni    = 1'b0;
    start     = 1'b0;
    kind_i    = KindInsert;
    key_i     = '0;
    payload_i = '0;
    tbl_count = 0;

    // directed part
    queue_cmd(KindDelete, 32'sd0, 32'h0);                  // delete from empty table
    queue_cmd(KindInsert, 32'sh8000_0000, 32'h0000_0000);  // insert into empty, min key
    queue_cmd(KindInsert, 32'sh7fff_ffff, 32'hffff_ffff);
    queue_cmd(KindInsert, 32'sd0, 32'ha5a5_a5a5);
    queue_cmd(KindInsert, 32'sd0, 32'h5a5a_5a5a);           // equal key goes first
    queue_cmd(KindInsert, -32'sd1, 32'h1234_5678);
    queue_cmd(KindDelete, 32'sd5, 32'hffff_ffff);           // absent key
    queue_cmd(KindDelete, 32'sd0, 32'h0);
    queue_cmd(KindDelete, 32'sh7fff_ffff, 32'h0);
    queue_cmd(KindDelete, 32'sh8000_0000, 32'h0);
    for (i = 0; i < 14; i++) begin
      queue_cmd(KindInsert, (i % 2) ? 32'sd100 - 7 * i : -32'sd50 + 9 * i, $urandom);
    end
    queue_cmd(KindInsert, 32'sd3, 32'hdead_beef);           // table full
    queue_cmd(KindDelete, 32'sd7777, 32'h0);                // absent key on full table

    // random part: alternating fill and drain phases
    fill_mode = 1'b0;
    mode_left = 0;
    for (n = 0; n < 1875; n++) begin
      if (mode_left == 0) begin
        fill_mode = ~fill_mode;
        mode_left = $urandom_range(20, 60);
      end
      mode_left--;
      if ($urandom_range(0, 99) < (fill_mode ? 75 : 25)) begin
        case ($urandom_range(0, 9))
          0, 1, 2: k = $urandom;
          3: k = ($urandom_range(0, 1)) ? 32'sh8000_0000 + $urandom_range(0, 1)
                                         : 32'sh7fff_ffff - $urandom_range(0, 1);
          4, 5: k = (live_keys.size() > 0)
                    ? live_keys[$urandom_range(0, live_keys.size() - 1)] : $urandom;
          default: k = $signed($urandom_range(0, 16)) - 32'sd8;
        endcase
        queue_cmd(KindInsert, k, $urandom);
      end else begin
        if (live_keys.size() > 0 && $urandom_range(0, 99) < 70) begin
          k = live_keys[$urandom_range(0, live_keys.size() - 1)];
        end else if ($urandom_range(0, 1)) begin
          k = $urandom;
        end else begin
          k = $signed($urandom_range(0, 16)) - 32'sd8;
        end
        queue_cmd(KindDelete, k, $urandom);
      end
    end
    total_cmds = pending_cmds.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cmds < total_cmds || expected_results.size() > 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
